### src/spk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk_pkg
// shared types, register codes and round functions for the cbc cipher
// ----------------------------------------------------------------------------
package spk_pkg;

    localparam int ROUNDS      = 32;
    localparam int RK_AW       = $clog2(ROUNDS);
    localparam int WORD_W      = 64;
    localparam int CNT_W       = 5;
    localparam int CFG_AW      = 6;

    typedef enum logic [2:0] {
        REG_KEY_LOW  = 3'd0,
        REG_KEY_HIGH = 3'd1,
        REG_IV_LOW   = 3'd2,
        REG_IV_HIGH  = 3'd3,
        REG_MODE     = 3'd4
    } reg_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_KINIT = 5'b00010,
        ST_KEXP  = 5'b00100,
        ST_RUN   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] key_low;
        logic [WORD_W-1:0] key_high;
        logic [WORD_W-1:0] iv_low;
        logic [WORD_W-1:0] iv_high;
        logic              decrypt_mode;
    } cfg_regs_t;

    typedef struct packed {
        logic                key_load;
        logic                chain_load;
        logic [2*WORD_W-1:0] iv_next;
    } cfg_evt_t;

    typedef struct packed {
        logic             load;
        logic             round;
        logic             emit;
        logic             key_init;
        logic             key_step;
        logic [RK_AW-1:0] cnt;
    } dp_cmd_t;

    typedef struct packed {
        logic two_pend;
        logic out_free;
    } dp_stat_t;

    // one speck encryption round, x is the high word
    function automatic logic [2*WORD_W-1:0] enc_round(input logic [WORD_W-1:0] x,
                                                      input logic [WORD_W-1:0] y,
                                                      input logic [WORD_W-1:0] k);
        logic [WORD_W-1:0] xn;
        logic [WORD_W-1:0] yn;
        xn = ({x[7:0], x[WORD_W-1:8]} + y) ^ k;
        yn = {y[WORD_W-4:0], y[WORD_W-1:WORD_W-3]} ^ xn;
        return {xn, yn};
    endfunction

    // inverse round
    function automatic logic [2*WORD_W-1:0] dec_round(input logic [WORD_W-1:0] x,
                                                      input logic [WORD_W-1:0] y,
                                                      input logic [WORD_W-1:0] k);
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] yn;
        logic [WORD_W-1:0] d;
        t  = x ^ y;
        yn = {t[2:0], t[WORD_W-1:3]};
        d  = (x ^ k) - yn;
        return {{d[WORD_W-9:0], d[WORD_W-1:WORD_W-8]}, yn};
    endfunction

endpackage

### src/spk_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk_cfg
// apb register file for key, iv and mode, with write events
// ----------------------------------------------------------------------------
module spk_cfg
    import spk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output cfg_regs_t         regs,
    output cfg_evt_t          evt
);

    logic [WORD_W-1:0] key_low_reg,  key_low_next;
    logic [WORD_W-1:0] key_high_reg, key_high_next;
    logic [WORD_W-1:0] iv_low_reg,   iv_low_next;
    logic [WORD_W-1:0] iv_high_reg,  iv_high_next;
    logic              mode_reg,     mode_next;
    logic              wr;
    reg_sel_t          sel;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign sel    = reg_sel_t'(paddr[5:3]);

    always_comb
    begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        iv_low_next   = iv_low_reg;
        iv_high_next  = iv_high_reg;
        mode_next     = mode_reg;
        evt.key_load   = 1'b0;
        evt.chain_load = 1'b0;
        if (wr)
        begin
            unique case (sel)
                REG_KEY_LOW:
                begin
                    key_low_next = pwdata;
                    evt.key_load = 1'b1;
                end
                REG_KEY_HIGH:
                begin
                    key_high_next = pwdata;
                    evt.key_load  = 1'b1;
                end
                REG_IV_LOW:
                begin
                    iv_low_next    = pwdata;
                    evt.chain_load = 1'b1;
                end
                REG_IV_HIGH:
                begin
                    iv_high_next   = pwdata;
                    evt.chain_load = 1'b1;
                end
                REG_MODE:
                begin
                    mode_next      = pwdata[0];
                    evt.chain_load = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        evt.iv_next = {iv_high_next, iv_low_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            iv_low_reg   <= '0;
            iv_high_reg  <= '0;
            mode_reg     <= 1'b0;
        end
        else
        begin
            key_low_reg  <= key_low_next;
            key_high_reg <= key_high_next;
            iv_low_reg   <= iv_low_next;
            iv_high_reg  <= iv_high_next;
            mode_reg     <= mode_next;
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_KEY_LOW:  prdata = key_low_reg;
            REG_KEY_HIGH: prdata = key_high_reg;
            REG_IV_LOW:   prdata = iv_low_reg;
            REG_IV_HIGH:  prdata = iv_high_reg;
            REG_MODE:     prdata = {63'd0, mode_reg};
            default:      prdata = '0;
        endcase
    end

    assign regs.key_low      = key_low_reg;
    assign regs.key_high     = key_high_reg;
    assign regs.iv_low       = iv_low_reg;
    assign regs.iv_high      = iv_high_reg;
    assign regs.decrypt_mode = mode_reg;

endmodule

### src/spk_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk_ctrl
// sequencer for key expansion, round loop and result hand-off
// ----------------------------------------------------------------------------
module spk_ctrl
    import spk_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  cfg_evt_t evt,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [RK_AW-1:0] LAST_ROUND = RK_AW'(ROUNDS - 1);
    localparam logic [RK_AW-1:0] LAST_STEP  = RK_AW'(ROUNDS - 2);

    state_t           state_reg, state_next;
    logic [RK_AW-1:0] cnt_reg,   cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.load     = 1'b0;
        cmd.round    = 1'b0;
        cmd.emit     = 1'b0;
        cmd.key_init = 1'b0;
        cmd.key_step = 1'b0;
        cmd.cnt      = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_KINIT:
            begin
                cmd.key_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_KEXP;
            end
            ST_KEXP:
            begin
                cmd.key_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RUN:
            begin
                cmd.round = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ROUND)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cnt_next = '0;
                    // a full last block still owes the padding block
                    state_next = stat.two_pend ? ST_RUN : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (evt.key_load)
        begin
            state_next = ST_KINIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_KINIT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### src/spk_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk_dp
// round unit, key store, cbc chain, padding and output register
// ----------------------------------------------------------------------------
module spk_dp
    import spk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  cfg_regs_t           regs,
    input  cfg_evt_t            evt,
    input  logic [WORD_W-1:0]   data_low,
    input  logic [WORD_W-1:0]   data_high,
    input  logic [CNT_W-1:0]    byte_count,
    input  logic                last_in,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [WORD_W-1:0]   result_low,
    output logic [WORD_W-1:0]   result_high,
    output logic [CNT_W-1:0]    valid_bytes,
    output logic                last_out,
    output logic                pad_error
);

    localparam logic [CNT_W-1:0]    FULL  = CNT_W'(16);
    localparam logic [2*WORD_W-1:0] FILL  = {16{8'h10}};

    logic [WORD_W-1:0]   rk_mem [0:ROUNDS-1];
    logic [WORD_W-1:0]   rk_reg;
    logic                rk_we;
    logic [RK_AW-1:0]    rk_waddr;
    logic [WORD_W-1:0]   rk_wdata;
    logic [RK_AW-1:0]    rk_nxt;
    logic [RK_AW-1:0]    rk_raddr;

    logic [WORD_W-1:0]   ka_reg, ka_next;
    logic [WORD_W-1:0]   kb_reg, kb_next;

    logic [WORD_W-1:0]   x_reg, x_next;
    logic [WORD_W-1:0]   y_reg, y_next;
    logic [2*WORD_W-1:0] chain_reg, chain_next;
    logic [2*WORD_W-1:0] cblk_reg, cblk_next;
    logic                last_reg, last_next;
    logic                two_reg, two_next;

    logic                ov_reg, ov_next;
    logic [WORD_W-1:0]   olo_reg, olo_next;
    logic [WORD_W-1:0]   ohi_reg, ohi_next;
    logic [CNT_W-1:0]    ovb_reg, ovb_next;
    logic                olast_reg, olast_next;
    logic                oerr_reg, oerr_next;

    logic [CNT_W-1:0]    n_sat;
    logic [CNT_W-1:0]    n_eff;
    logic [7:0]          pad_byte;
    logic [2*WORD_W-1:0] din;
    logic [2*WORD_W-1:0] padded;
    logic [2*WORD_W-1:0] ct;
    logic [2*WORD_W-1:0] pt;
    logic [7:0]          p;
    logic                pad_ok;
    logic [2*WORD_W-1:0] rnd;
    logic [WORD_W-1:0]   ka_step;

    // key schedule step
    assign ka_step = ({ka_reg[7:0], ka_reg[WORD_W-1:8]} + kb_reg)
                     ^ {{(WORD_W-RK_AW){1'b0}}, cmd.cnt};

    always_comb
    begin
        ka_next  = ka_reg;
        kb_next  = kb_reg;
        rk_we    = 1'b0;
        rk_waddr = '0;
        rk_wdata = regs.key_low;
        if (cmd.key_init)
        begin
            ka_next = regs.key_high;
            kb_next = regs.key_low;
            rk_we   = 1'b1;
        end
        else if (cmd.key_step)
        begin
            ka_next  = ka_step;
            kb_next  = {kb_reg[WORD_W-4:0], kb_reg[WORD_W-1:WORD_W-3]} ^ ka_step;
            rk_we    = 1'b1;
            rk_waddr = cmd.cnt + 1'b1;
            rk_wdata = kb_next;
        end
    end

    // prefetch the key for the following round; idle and done point at the first
    assign rk_nxt   = cmd.round ? (cmd.cnt + 1'b1) : '0;
    assign rk_raddr = regs.decrypt_mode ? ~rk_nxt : rk_nxt;

    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            rk_mem[rk_waddr] <= rk_wdata;
        end
        rk_reg <= rk_mem[rk_raddr];
    end

    // encrypt padding: bytes at and above the count take the pad value
    always_comb
    begin
        n_sat    = (byte_count > FULL) ? FULL : byte_count;
        n_eff    = last_in ? n_sat : FULL;
        pad_byte = {3'd0, FULL - n_eff};
        din      = {data_high, data_low};
        for (int j = 0; j < 16; j++)
        begin
            padded[8*j +: 8] = (CNT_W'(j) < n_eff) ? din[8*j +: 8] : pad_byte;
        end
    end

    // decrypt padding check
    assign ct = {x_reg, y_reg};
    assign pt = ct ^ chain_reg;
    assign p  = pt[127:120];

    always_comb
    begin
        pad_ok = (p >= 8'd1) && (p <= 8'd16);
        for (int j = 0; j < 16; j++)
        begin
            if (({1'b0, p} + 9'(j)) >= 9'd16 && pt[8*j +: 8] != p)
            begin
                pad_ok = 1'b0;
            end
        end
    end

    assign rnd = regs.decrypt_mode ? dec_round(x_reg, y_reg, rk_reg)
                                   : enc_round(x_reg, y_reg, rk_reg);

    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        chain_next = chain_reg;
        cblk_next  = cblk_reg;
        last_next  = last_reg;
        two_next   = two_reg;
        ov_next    = ov_reg & ~out_ready;
        olo_next   = olo_reg;
        ohi_next   = ohi_reg;
        ovb_next   = ovb_reg;
        olast_next = olast_reg;
        oerr_next  = oerr_reg;

        if (cmd.load)
        begin
            last_next = last_in;
            if (regs.decrypt_mode)
            begin
                {x_next, y_next} = din;
                cblk_next        = din;
                two_next         = 1'b0;
            end
            else
            begin
                {x_next, y_next} = padded ^ chain_reg;
                two_next         = last_in & (n_sat == FULL);
            end
        end
        else if (cmd.round)
        begin
            {x_next, y_next} = rnd;
        end
        else if (cmd.emit)
        begin
            ov_next = 1'b1;
            if (regs.decrypt_mode)
            begin
                {ohi_next, olo_next} = pt;
                olast_next = last_reg;
                oerr_next  = last_reg & ~pad_ok;
                ovb_next   = !last_reg ? FULL : (pad_ok ? FULL - p[CNT_W-1:0] : '0);
                chain_next = last_reg ? {regs.iv_high, regs.iv_low} : cblk_reg;
            end
            else
            begin
                {ohi_next, olo_next} = ct;
                olast_next = last_reg & ~two_reg;
                oerr_next  = 1'b0;
                ovb_next   = FULL;
                chain_next = (last_reg & ~two_reg) ? {regs.iv_high, regs.iv_low} : ct;
                if (two_reg)
                begin
                    {x_next, y_next} = FILL ^ ct;
                    two_next         = 1'b0;
                end
            end
        end

        if (evt.chain_load)
        begin
            chain_next = evt.iv_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= '0;
            last_reg  <= 1'b0;
            two_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            chain_reg <= chain_next;
            last_reg  <= last_next;
            two_reg   <= two_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ka_reg    <= ka_next;
        kb_reg    <= kb_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        cblk_reg  <= cblk_next;
        olo_reg   <= olo_next;
        ohi_reg   <= ohi_next;
        ovb_reg   <= ovb_next;
        olast_reg <= olast_next;
        oerr_reg  <= oerr_next;
    end

    assign stat.two_pend = two_reg;
    assign stat.out_free = ~ov_reg | out_ready;

    assign out_valid   = ov_reg;
    assign result_low  = olo_reg;
    assign result_high = ohi_reg;
    assign valid_bytes = ovb_reg;
    assign last_out    = olast_reg;
    assign pad_error   = oerr_reg;

endmodule

### src/speck128_cbc_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speck128_cbc_cipher
// speck128/128 cbc encrypt with pkcs#7 padding, decrypt with padding check
// ----------------------------------------------------------------------------
// round loop: a single shared round unit steps through 32 keys read from the
//   key store; a new input word is taken only in idle, once the previous
//   result is in the output register; a full last encrypt block adds a
//   padding block
// reset: asynchronous, active low; the chain and datapath flags clear to zero,
//   then a key expansion runs (and again after each key write) with no input
module speck128_cbc_cipher
    import spk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [135:0]      s_axis_tdata,  // data_low, data_high, byte_count, zero fill
    input  logic              s_axis_tlast,  // last_in

    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [135:0]      m_axis_tdata,  // result_low, result_high, valid_bytes, zero fill
    output logic              m_axis_tlast,  // last_out
    output logic              m_axis_tuser,  // pad_error

    // register port: key_low 0x00, key_high 0x08, iv_low 0x10, iv_high 0x18, mode 0x20
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    cfg_regs_t         regs;
    cfg_evt_t          evt;
    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [WORD_W-1:0] result_low;
    logic [WORD_W-1:0] result_high;
    logic [CNT_W-1:0]  valid_bytes;

    // register file; key writes restart expansion, iv and mode writes reload the chain
    spk_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .regs    (regs),
        .evt     (evt)
    );

    // sequencer: idle, key expansion, 32 rounds, hand-off into the output register
    spk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .evt      (evt),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: the output register lets the next word in while a result waits
    spk_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .regs        (regs),
        .evt         (evt),
        .data_low    (s_axis_tdata[63:0]),
        .data_high   (s_axis_tdata[127:64]),
        .byte_count  (s_axis_tdata[132:128]),
        .last_in     (s_axis_tlast),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .result_low  (result_low),
        .result_high (result_high),
        .valid_bytes (valid_bytes),
        .last_out    (m_axis_tlast),
        .pad_error   (m_axis_tuser)
    );

    // pack result fields, low field first
    assign m_axis_tdata = {3'd0, valid_bytes, result_high, result_low};

endmodule

### src/spk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk_checker
// port-level checks on the result stream
// ----------------------------------------------------------------------------
module spk_checker
    import spk_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata,
    input logic         m_axis_tlast,
    input logic         m_axis_tuser
);

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // padding errors only close a message
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("pad error on a word that is not last");

    // a bad pad reports no bytes
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[132:128] == 5'd0)
        else $error("pad error with nonzero byte count");

    // byte count never exceeds a block
    a_vb_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[132] || m_axis_tdata[131:128] == 4'd0)
        else $error("valid byte count above sixteen");

endmodule

bind speck128_cbc_cipher spk_checker u_spk_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
